// ===== hdl/jsv_pkg.sv =====
`timescale 1ns / 1ps
package jsv_pkg;

  typedef enum logic [15:0] {
    M_TOP       = 16'h0001,
    M_ARR_FIRST = 16'h0002,
    M_OBJ_FIRST = 16'h0004,
    M_KEY_EXP   = 16'h0008,
    M_COLON     = 16'h0010,
    M_VALUE     = 16'h0020,
    M_AFTER     = 16'h0040,
    M_STRING    = 16'h0080,
    M_ESC       = 16'h0100,
    M_HEX       = 16'h0200,
    M_SURR_BS   = 16'h0400,
    M_SURR_U    = 16'h0800,
    M_HEX_LOW   = 16'h1000,
    M_LITERAL   = 16'h2000,
    M_NUMBER    = 16'h4000,
    M_DEAD      = 16'h8000
  } mode_t;

  localparam logic [1:0] KIND_KEY     = 2'd0;
  localparam logic [1:0] KIND_STRING  = 2'd1;
  localparam logic [1:0] KIND_NUMBER  = 2'd2;
  localparam logic [1:0] KIND_VERDICT = 2'd3;

  localparam logic [1:0] VERD_OK      = 2'd0;
  localparam logic [1:0] VERD_BAD     = 2'd1;
  localparam logic [1:0] VERD_NESTING = 2'd2;

  localparam logic [3:0] LIMIT_RESET = 4'd12;

  // Up to five results from one byte, packed as a run
  typedef struct packed {
    logic [2:0]      count;
    logic [1:0]      kind;
    logic [3:0][7:0] bytes;
    logic [3:0]      depth;
    logic            verdict;
    logic [1:0]      code;
    logic [3:0]      vdepth;
  } run_t;

  function automatic logic [7:0] lit_char(input logic [3:0] idx);
    logic [7:0] c;
    begin
      case (idx)
        4'd0:  c = "t";
        4'd1:  c = "r";
        4'd2:  c = "u";
        4'd3:  c = "e";
        4'd5:  c = "f";
        4'd6:  c = "a";
        4'd7:  c = "l";
        4'd8:  c = "s";
        4'd9:  c = "e";
        4'd11: c = "n";
        4'd12: c = "u";
        4'd13: c = "l";
        4'd14: c = "l";
        default: c = 8'd0;
      endcase
      return c;
    end
  endfunction

endpackage

// ===== hdl/jsv_parser.sv =====
`timescale 1ns / 1ps
module jsv_parser #(
  parameter int STACK_DEPTH = 12,
  parameter int DW = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [7:0]       data_byte,
  input  logic             end_doc,
  input  logic [3:0]       limit,
  output jsv_pkg::run_t    run
);

  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  jsv_pkg::mode_t mode_r, mode_nxt;
  logic [STACK_DEPTH-1:0] stack_r, stack_nxt;
  logic [DW-1:0]  depth_r, depth_nxt;
  logic [15:0]    hex_r, hex_nxt;
  logic [1:0]     hcnt_r, hcnt_nxt;
  logic [9:0]     surr_r, surr_nxt;
  logic [3:0]     lit_r, lit_nxt;
  logic [2:0]     nph_r, nph_nxt;
  logic [1:0]     err_r, err_nxt;
  logic           key_r, key_nxt;

  logic [7:0]  c;
  logic        ws, dig, ee;
  logic [3:0]  hv;
  logic        hok;
  logic [15:0] hacc;
  logic [20:0] cp;
  logic        do_cp;
  logic [DW-1:0] lim;
  logic        top_obj;
  logic [1:0]  kind;
  logic [2:0]  cnt;
  logic [3:0][7:0] bts;
  logic [2:0]  nnext;
  logic        ntake, nend;
  logic        after_chk;
  logic        ok;
  logic [3:0]  ldx;

  assign c   = data_byte;
  assign ws  = (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d);
  assign dig = (c >= "0") && (c <= "9");
  assign ee  = (c == "e") || (c == "E");
  assign top_obj = (depth_r == '0) ? 1'b0 : stack_r[SW'(depth_r - DW'(1))];

  // Hex digit value
  always_comb begin
    hok = 1'b1;
    hv  = 4'd0;
    if (dig) hv = 4'(c - "0");
    else if (c >= "a" && c <= "f") hv = 4'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") hv = 4'(c - "A" + 8'd10);
    else hok = 1'b0;
  end
  assign hacc = {hex_r[11:0], hv};

  always_comb begin
    lim = (limit > 4'(STACK_DEPTH) && STACK_DEPTH < 16) ? DW'(STACK_DEPTH) : DW'(limit);
  end

  // Number phase transitions
  always_comb begin
    nnext = 3'd0; ntake = 1'b0; nend = 1'b0;
    case (nph_r)
      3'd0: if (c == "0") begin nnext = 3'd1; ntake = 1'b1; end
            else if (dig) begin nnext = 3'd2; ntake = 1'b1; end
      3'd1: if (dig) ntake = 1'b0;
            else if (c == ".") begin nnext = 3'd3; ntake = 1'b1; end
            else if (ee) begin nnext = 3'd5; ntake = 1'b1; end
            else nend = 1'b1;
      3'd2: if (dig) begin nnext = 3'd2; ntake = 1'b1; end
            else if (c == ".") begin nnext = 3'd3; ntake = 1'b1; end
            else if (ee) begin nnext = 3'd5; ntake = 1'b1; end
            else nend = 1'b1;
      3'd3: if (dig) begin nnext = 3'd4; ntake = 1'b1; end
      3'd4: if (dig) begin nnext = 3'd4; ntake = 1'b1; end
            else if (ee) begin nnext = 3'd5; ntake = 1'b1; end
            else nend = 1'b1;
      3'd5: if (c == "+" || c == "-") begin nnext = 3'd6; ntake = 1'b1; end
            else if (dig) begin nnext = 3'd7; ntake = 1'b1; end
      3'd6: if (dig) begin nnext = 3'd7; ntake = 1'b1; end
      default: if (dig) begin nnext = 3'd7; ntake = 1'b1; end
               else nend = 1'b1;
    endcase
  end

  // Classify the byte against the current mode
  always_comb begin
    mode_nxt = mode_r; stack_nxt = stack_r; depth_nxt = depth_r;
    hex_nxt = hex_r; hcnt_nxt = hcnt_r; surr_nxt = surr_r; lit_nxt = lit_r;
    nph_nxt = nph_r; err_nxt = err_r; key_nxt = key_r;
    kind = key_r ? jsv_pkg::KIND_KEY : jsv_pkg::KIND_STRING;
    cnt = 3'd0; bts = '0; cp = '0; do_cp = 1'b0; after_chk = 1'b0;
    ldx = 4'd0;
    if (err_r == 2'd0) begin
      if (mode_r == jsv_pkg::M_NUMBER) begin
        if (ntake) begin
          nph_nxt = nnext; kind = jsv_pkg::KIND_NUMBER; cnt = 3'd1; bts[0] = c;
        end else if (nend) begin
          mode_nxt = jsv_pkg::M_AFTER; after_chk = 1'b1;
        end else begin
          err_nxt = jsv_pkg::VERD_BAD; mode_nxt = jsv_pkg::M_DEAD;
        end
      end
      case (mode_r)
        jsv_pkg::M_TOP, jsv_pkg::M_VALUE, jsv_pkg::M_ARR_FIRST: begin
          if (ws) begin
          end else if (mode_r == jsv_pkg::M_ARR_FIRST && c == "]") begin
            depth_nxt = depth_r - DW'(1); mode_nxt = jsv_pkg::M_AFTER;
          end else if (c == "{" || c == "[") begin
            if (depth_r >= lim) begin
              err_nxt = jsv_pkg::VERD_NESTING; mode_nxt = jsv_pkg::M_DEAD;
            end else begin
              stack_nxt[SW'(depth_r)] = (c == "{");
              depth_nxt = depth_r + DW'(1);
              mode_nxt = (c == "{") ? jsv_pkg::M_OBJ_FIRST : jsv_pkg::M_ARR_FIRST;
            end
          end else if (c == "\"") begin
            key_nxt = 1'b0; mode_nxt = jsv_pkg::M_STRING;
          end else if (c == "t" || c == "f" || c == "n") begin
            lit_nxt = (c == "t") ? 4'd1 : (c == "f") ? 4'd6 : 4'd12;
            mode_nxt = jsv_pkg::M_LITERAL;
          end else if (c == "-" || dig) begin
            nph_nxt = (c == "-") ? 3'd0 : (c == "0") ? 3'd1 : 3'd2;
            mode_nxt = jsv_pkg::M_NUMBER;
            kind = jsv_pkg::KIND_NUMBER; cnt = 3'd1; bts[0] = c;
          end else begin
            err_nxt = jsv_pkg::VERD_BAD; mode_nxt = jsv_pkg::M_DEAD;
          end
        end
        jsv_pkg::M_OBJ_FIRST, jsv_pkg::M_KEY_EXP: begin
          if (ws) begin
          end else if (c == "}" && mode_r == jsv_pkg::M_OBJ_FIRST) begin
            depth_nxt = depth_r - DW'(1); mode_nxt = jsv_pkg::M_AFTER;
          end else if (c == "\"") begin
            key_nxt = 1'b1; mode_nxt = jsv_pkg::M_STRING;
          end else begin
            err_nxt = jsv_pkg::VERD_BAD; mode_nxt = jsv_pkg::M_DEAD;
          end
        end
        jsv_pkg::M_COLON: begin
          if (ws) begin
          end else if (c == ":") mode_nxt = jsv_pkg::M_VALUE;
          else begin
            err_nxt = jsv_pkg::VERD_BAD; mode_nxt = jsv_pkg::M_DEAD;
          end
        end
        jsv_pkg::M_AFTER: after_chk = 1'b1;
        jsv_pkg::M_STRING: begin
          if (c == "\"") mode_nxt = key_r ? jsv_pkg::M_COLON : jsv_pkg::M_AFTER;
          else if (c < 8'h20) begin
            err_nxt = jsv_pkg::VERD_BAD; mode_nxt = jsv_pkg::M_DEAD;
          end else if (c == "\\") mode_nxt = jsv_pkg::M_ESC;
          else begin
            cnt = 3'd1; bts[0] = c;
          end
        end
        jsv_pkg::M_ESC: begin
          mode_nxt = jsv_pkg::M_STRING; cnt = 3'd1;
          case (c)
            "\"", "\\", "/": bts[0] = c;
            "b": bts[0] = 8'd8;
            "f": bts[0] = 8'd12;
            "n": bts[0] = 8'd10;
            "r": bts[0] = 8'd13;
            "t": bts[0] = 8'd9;
            "u": begin
              cnt = 3'd0; hex_nxt = '0; hcnt_nxt = '0; mode_nxt = jsv_pkg::M_HEX;
            end
            default: begin
              cnt = 3'd0; err_nxt = jsv_pkg::VERD_BAD; mode_nxt = jsv_pkg::M_DEAD;
            end
          endcase
        end
        jsv_pkg::M_HEX, jsv_pkg::M_HEX_LOW: begin
          if (!hok) begin
            err_nxt = jsv_pkg::VERD_BAD; mode_nxt = jsv_pkg::M_DEAD;
          end else begin
            hex_nxt = hacc;
            if (hcnt_r != 2'd3) hcnt_nxt = hcnt_r + 2'd1;
            else begin
              hcnt_nxt = 2'd0;
              if (mode_r == jsv_pkg::M_HEX_LOW) begin
                if (hacc[15:10] != 6'b110111) begin
                  err_nxt = jsv_pkg::VERD_BAD; mode_nxt = jsv_pkg::M_DEAD;
                end else begin
                  cp = 21'h10000 + {1'b0, surr_r, hacc[9:0]};
                  do_cp = 1'b1; mode_nxt = jsv_pkg::M_STRING;
                end
              end else if (hacc[15:10] == 6'b110110) begin
                surr_nxt = hacc[9:0]; mode_nxt = jsv_pkg::M_SURR_BS;
              end else if (hacc[15:10] == 6'b110111) begin
                err_nxt = jsv_pkg::VERD_BAD; mode_nxt = jsv_pkg::M_DEAD;
              end else begin
                cp = {5'd0, hacc}; do_cp = 1'b1; mode_nxt = jsv_pkg::M_STRING;
              end
            end
          end
        end
        jsv_pkg::M_SURR_BS: begin
          if (c == "\\") mode_nxt = jsv_pkg::M_SURR_U;
          else begin
            err_nxt = jsv_pkg::VERD_BAD; mode_nxt = jsv_pkg::M_DEAD;
          end
        end
        jsv_pkg::M_SURR_U: begin
          if (c == "u") begin
            hex_nxt = '0; hcnt_nxt = '0; mode_nxt = jsv_pkg::M_HEX_LOW;
          end else begin
            err_nxt = jsv_pkg::VERD_BAD; mode_nxt = jsv_pkg::M_DEAD;
          end
        end
        jsv_pkg::M_LITERAL: begin
          if (c != jsv_pkg::lit_char(lit_r)) begin
            err_nxt = jsv_pkg::VERD_BAD; mode_nxt = jsv_pkg::M_DEAD;
          end else begin
            ldx = lit_r + 4'd1;
            lit_nxt = ldx;
            if (jsv_pkg::lit_char(ldx) == 8'd0) mode_nxt = jsv_pkg::M_AFTER;
          end
        end
        default: begin
        end
      endcase
      // Byte after a value, also reached when a number ends
      if (after_chk && !ws) begin
        if (depth_r == '0 || depth_r > DW'(STACK_DEPTH)) begin
          err_nxt = jsv_pkg::VERD_BAD; mode_nxt = jsv_pkg::M_DEAD;
        end else if (c == ",") begin
          mode_nxt = top_obj ? jsv_pkg::M_KEY_EXP : jsv_pkg::M_VALUE;
        end else if ((top_obj && c == "}") || (!top_obj && c == "]")) begin
          depth_nxt = depth_r - DW'(1);
        end else begin
          err_nxt = jsv_pkg::VERD_BAD; mode_nxt = jsv_pkg::M_DEAD;
        end
      end
      // UTF-8 encode a decoded code point
      if (do_cp) begin
        if (cp <= 21'h7f) begin
          cnt = 3'd1; bts[0] = cp[7:0];
        end else if (cp <= 21'h7ff) begin
          cnt = 3'd2; bts[0] = 8'hc0 | {3'd0, cp[10:6]}; bts[1] = 8'h80 | {2'd0, cp[5:0]};
        end else if (cp <= 21'hffff) begin
          cnt = 3'd3; bts[0] = 8'he0 | {4'd0, cp[15:12]};
          bts[1] = 8'h80 | {2'd0, cp[11:6]}; bts[2] = 8'h80 | {2'd0, cp[5:0]};
        end else begin
          cnt = 3'd4; bts[0] = 8'hf0 | {5'd0, cp[20:18]};
          bts[1] = 8'h80 | {2'd0, cp[17:12]}; bts[2] = 8'h80 | {2'd0, cp[11:6]};
          bts[3] = 8'h80 | {2'd0, cp[5:0]};
        end
      end
    end
    ok = (depth_nxt == '0) && (mode_nxt == jsv_pkg::M_AFTER ||
         (mode_nxt == jsv_pkg::M_NUMBER &&
          (nph_nxt == 3'd1 || nph_nxt == 3'd2 || nph_nxt == 3'd4 || nph_nxt == 3'd7)));
    run.count   = cnt;
    run.kind    = kind;
    run.bytes   = bts;
    run.depth   = 4'(depth_nxt);
    run.verdict = end_doc;
    run.code    = (err_nxt != 2'd0) ? err_nxt : (ok ? jsv_pkg::VERD_OK : jsv_pkg::VERD_BAD);
    run.vdepth  = 4'(depth_nxt);
  end

  // Advance parse state, restart on end of document
  always_ff @(posedge clk) begin
    if (!rst_n || (take && end_doc)) begin
      mode_r <= jsv_pkg::M_TOP; depth_r <= '0; hex_r <= '0; hcnt_r <= '0;
      surr_r <= '0; lit_r <= '0; nph_r <= '0; err_r <= '0; key_r <= 1'b0;
    end else if (take) begin
      mode_r <= mode_nxt; depth_r <= depth_nxt; hex_r <= hex_nxt;
      hcnt_r <= hcnt_nxt; surr_r <= surr_nxt; lit_r <= lit_nxt;
      nph_r <= nph_nxt; err_r <= err_nxt; key_r <= key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) stack_r <= stack_nxt;
  end

endmodule

// ===== hdl/jsv_queue.sv =====
`timescale 1ns / 1ps
module jsv_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  jsv_pkg::run_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output jsv_pkg::run_t rd_data,
  output logic          empty
);

  jsv_pkg::run_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  // Hold runs between classification and delivery
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

// ===== hdl/jsv_emitter.sv =====
`timescale 1ns / 1ps
module jsv_emitter (
  input  logic          clk,
  input  logic          rst_n,
  input  jsv_pkg::run_t run,
  input  logic          run_valid,
  output logic          run_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_item_kind,
  output logic [7:0]    out_content_byte,
  output logic [3:0]    out_open_depth,
  output logic [1:0]    out_verdict_code,
  output logic          out_last_of_run
);

  logic [2:0] idx_r;
  logic [2:0] total;
  logic       is_v;
  logic       last;
  logic       step;

  assign total = run.count + {2'd0, run.verdict};
  assign is_v  = (idx_r == run.count);
  assign last  = (idx_r + 3'd1 >= total);
  assign step  = run_valid && (total != 3'd0) && out_ready;

  // Present one result of the head run at a time
  assign out_valid        = run_valid && (total != 3'd0);
  assign out_item_kind    = is_v ? jsv_pkg::KIND_VERDICT : run.kind;
  assign out_content_byte = is_v ? 8'd0 : run.bytes[idx_r[1:0]];
  assign out_open_depth   = is_v ? run.vdepth : run.depth;
  assign out_verdict_code = is_v ? run.code : jsv_pkg::VERD_OK;
  assign out_last_of_run  = last;
  assign run_pop = run_valid && ((total == 3'd0) || (step && last));

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= 3'd0;
    else if (run_pop) idx_r <= 3'd0;
    else if (step) idx_r <= idx_r + 3'd1;
  end

endmodule

// ===== hdl/json_stream_validator.sv =====
`timescale 1ns / 1ps
// An accepted byte's run is registered in the queue before its results are offered.
// Throughput: one byte per cycle while each byte gives at most one result and the
// output is ready; a byte with several results holds the single output port until all go.
// A two-entry queue sits between the parser and the result emitter.
// Reset (rst_n low, synchronous): parser at top value, queue empty, limit 12.
module json_stream_validator #(
  parameter int STACK_DEPTH = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_document,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_item_kind,
  output logic [7:0] out_content_byte,
  output logic [3:0] out_open_depth,
  output logic [1:0] out_verdict_code,
  output logic       out_last_of_run
);

  localparam int DW = $clog2(STACK_DEPTH + 1) + 1;

  logic [3:0]    limit_r;
  jsv_pkg::run_t run_in, run_out;
  logic          full, empty, pop, take;

  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= jsv_pkg::LIMIT_RESET;
    else if (cfg_we) limit_r <= cfg_wdata;
  end

  assign in_ready = !full;
  assign take     = in_valid && in_ready;

  jsv_parser #(.STACK_DEPTH(STACK_DEPTH), .DW(DW)) u_parser (
    .clk(clk), .rst_n(rst_n), .take(take), .data_byte(in_data_byte),
    .end_doc(in_end_of_document), .limit(limit_r), .run(run_in)
  );

  jsv_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(take), .wr_data(run_in), .full(full),
    .rd_en(pop), .rd_data(run_out), .empty(empty)
  );

  jsv_emitter u_emit (
    .clk(clk), .rst_n(rst_n), .run(run_out), .run_valid(!empty), .run_pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_item_kind(out_item_kind),
    .out_content_byte(out_content_byte), .out_open_depth(out_open_depth),
    .out_verdict_code(out_verdict_code), .out_last_of_run(out_last_of_run)
  );

endmodule
